// ===== sv/amst_pkg.sv =====
// Shared types and constants for the array multiset table.
package amst_pkg;

  // Width of the count and occupancy result fields
  localparam int OUT_W = 6;

  // Width of the incoming value field
  localparam int IN_VALUE_W = 32;

  // Request codes
  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_DELETE   = 2'd1,
    REQ_COUNT    = 2'd2,
    REQ_CONTAINS = 2'd3
  } req_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_DONE
  } state_t;

  // Controls from the sequencer to the compare unit
  typedef struct packed {
    logic start;    // clear the tallies for a new scan
    logic cmp_vld;  // read data on this cycle belongs to the scan
  } scan_ctl_t;

endpackage

// ===== sv/array_multiset_table.sv =====
// Array multiset table: unordered fixed-capacity store of values with insert/delete/count/contains.
// Insert: result registered, in the cycle after the item is accepted; one item each cycle
// while out_ready is high. Count, contains, delete: scan of the stored entries, then result.
// A delete hit fills its hole with the last entry. Scan reads one entry per cycle from the RAM.
// One item is worked on at a time; the next is taken once its result has left or is leaving.
// Reset clears the occupancy and control state; the entry RAM is not cleared.
module array_multiset_table #(
  parameter int TABLE_DEPTH = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_req_type,
  input  logic [amst_pkg::IN_VALUE_W-1:0] in_item_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_found,
  output logic [amst_pkg::OUT_W-1:0]     out_match_count,
  output logic [amst_pkg::OUT_W-1:0]     out_occupancy,
  output logic                           out_full_error
);
  import amst_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [VALUE_BITS-1:0] in_key;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]  last_idx;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [ADDR_W-1:0] cmp_idx_r, cmp_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [OUT_W-1:0]  out_count_r, out_count_nxt;
  logic [OUT_W-1:0]  out_occ_r, out_occ_nxt;
  logic              out_full_r, out_full_nxt;

  logic              in_fire;
  logic              issue;
  logic              is_full;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  scan_ctl_t         scan_ctl;
  logic              hit_found;
  logic [CNT_W-1:0]  hit_count;
  logic [ADDR_W-1:0] hit_first;

  // Only the low VALUE_BITS bits of the value take part
  generate
    if (VALUE_BITS <= IN_VALUE_W) begin : g_key_narrow
      assign in_key = in_item_value[VALUE_BITS-1:0];
    end else begin : g_key_wide
      assign in_key = {{(VALUE_BITS - IN_VALUE_W){1'b0}}, in_item_value};
    end
  endgenerate

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign is_full  = (total_r == CNT_W'(TABLE_DEPTH));
  assign issue    = (rd_idx_r < total_r);
  assign last_idx = total_r - CNT_W'(1);

  // Entry storage
  amst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared compare unit
  amst_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .cmp_idx   (cmp_idx_r),
    .rd_data   (ram_rdata),
    .key       (key_r),
    .hit_found (hit_found),
    .hit_count (hit_count),
    .hit_first (hit_first)
  );

  // Sequencer: next state, RAM controls and result
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    total_nxt     = total_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_count_nxt = out_count_r;
    out_occ_nxt   = out_occ_r;
    out_full_nxt  = out_full_r;
    ram_we        = 1'b0;
    ram_waddr     = total_r[ADDR_W-1:0];
    ram_wdata     = in_key;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_r[ADDR_W-1:0];
    scan_ctl      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt = req_t'(in_req_type);
          key_nxt = in_key;
          if (req_t'(in_req_type) == REQ_INSERT) begin
            // Append at the end, or refuse when full
            ram_we        = !is_full;
            total_nxt     = is_full ? total_r : total_r + CNT_W'(1);
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_count_nxt = '0;
            out_occ_nxt   = OUT_W'(total_nxt);
            out_full_nxt  = is_full;
          end else begin
            rd_idx_nxt     = '0;
            scan_ctl.start = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue a read and compare the previous one in the same cycle
        ram_re           = issue;
        cmp_vld_nxt      = issue;
        cmp_idx_nxt      = rd_idx_r[ADDR_W-1:0];
        rd_idx_nxt       = issue ? rd_idx_r + CNT_W'(1) : rd_idx_r;
        scan_ctl.cmp_vld = cmp_vld_r;
        if (!issue && !cmp_vld_r) begin
          state_nxt = (req_r == REQ_DELETE && hit_found) ? ST_DEL_RD : ST_DONE;
        end
      end

      ST_DEL_RD: begin
        // Fetch the last entry to fill the hole
        ram_re    = 1'b1;
        ram_raddr = last_idx[ADDR_W-1:0];
        state_nxt = ST_DEL_WR;
      end

      ST_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = hit_first;
        ram_wdata = ram_rdata;
        total_nxt = last_idx;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // Result slot is empty here: it was free when the item was taken
        out_valid_nxt = 1'b1;
        out_found_nxt = hit_found;
        out_count_nxt = (req_r == REQ_COUNT) ? OUT_W'(hit_count) : '0;
        out_occ_nxt   = OUT_W'(total_r);
        out_full_nxt  = 1'b0;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    key_r       <= key_nxt;
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    out_found_r <= out_found_nxt;
    out_count_r <= out_count_nxt;
    out_occ_r   <= out_occ_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_count = out_count_r;
  assign out_occupancy   = out_occ_r;
  assign out_full_error  = out_full_r;

endmodule

// ===== sv/amst_ram.sv =====
// Generic simple dual-port RAM with registered read.
module amst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/amst_scan.sv =====
// Shared compare unit: matches one stored entry per cycle against the key.
module amst_scan #(
  parameter int TABLE_DEPTH = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  amst_pkg::scan_ctl_t                ctl,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     cmp_idx,
  input  logic [VALUE_BITS-1:0]              rd_data,
  input  logic [VALUE_BITS-1:0]              key,
  output logic                               hit_found,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   hit_count,
  output logic [$clog2(TABLE_DEPTH)-1:0]     hit_first
);
  import amst_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  logic              hit;
  logic              found_r;
  logic [CNT_W-1:0]  count_r;
  logic [ADDR_W-1:0] first_r;

  // One equality compare per cycle
  assign hit = ctl.cmp_vld && (rd_data == key);

  // Tallies: any match and number of matches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      count_r <= '0;
    end else if (ctl.start) begin
      found_r <= 1'b0;
      count_r <= '0;
    end else if (hit) begin
      found_r <= 1'b1;
      count_r <= count_r + CNT_W'(1);
    end
  end

  // Slot of the first match
  always_ff @(posedge clk) begin
    if (hit && !found_r) begin
      first_r <= cmp_idx;
    end
  end

  assign hit_found = found_r;
  assign hit_count = count_r;
  assign hit_first = first_r;

endmodule
